// File: rtl/keyed_count_table_assert.svh
// Assertion macros used by the keyed count table top level.
// Depends on nothing; files that check their own logic include it.
`ifndef KEYED_COUNT_TABLE_ASSERT_SVH
`define KEYED_COUNT_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks a property on the rising clock edge, suppressed while reset is active.
`define KCT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, also evaluated while reset is active.
`define KCT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define KCT_ASSERT(label, clk, rst_n, prop, msg)
`define KCT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/kct_pkg.sv
// Shared types and codes for the keyed count table.
// Used by the search cell and the top level; depends on nothing.
package kct_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Search token handed from one cell to the next.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [DataW-1:0] count;
  } tok_t;

  // Write command broadcast to every cell at the end of a request.
  typedef struct packed {
    logic             ins;
    logic             upd;
    logic [DataW-1:0] count;
  } wr_t;

endpackage

// File: rtl/kct_cell.sv
// One table slot: stored key and count plus one stage of the search chain.
// Depends on kct_pkg.
module kct_cell #(
  parameter int unsigned CNT_W = 8,
  parameter int unsigned IDX   = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [CNT_W-1:0]          used_i,
  input  logic [kct_pkg::DataW-1:0] key_i,
  input  kct_pkg::wr_t              wr_i,
  input  kct_pkg::tok_t             tok_i,
  output kct_pkg::tok_t             tok_o
);
  import kct_pkg::*;

  logic [DataW-1:0] key_q;
  logic [DataW-1:0] count_q;
  logic             tok_valid_q;
  logic             tok_hit_q;
  logic [DataW-1:0] tok_count_q;
  logic             filled;
  logic             match;

  // Slots are filled in order, so a slot below the fill count holds an entry.
  assign filled = CNT_W'(IDX) < used_i;
  assign match  = filled && (key_q == key_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.ins && (used_i == CNT_W'(IDX))) begin
      key_q   <= key_i;
      count_q <= wr_i.count;
    end else if (wr_i.upd && match) begin
      count_q <= wr_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  // The first filled slot that matches claims the token.
  always_ff @(posedge clk_i) begin
    if (tok_i.valid && !tok_i.hit && match) begin
      tok_hit_q   <= 1'b1;
      tok_count_q <= count_q;
    end else begin
      tok_hit_q   <= tok_i.hit;
      tok_count_q <= tok_i.count;
    end
  end

  assign tok_o = '{valid: tok_valid_q, hit: tok_hit_q, count: tok_count_q};

endmodule

// File: rtl/keyed_count_table.sv
// Keyed count table: a request is searched through a chain of TABLE_DEPTH cells.
// The search token steps one cell per cycle, then the search result and the output are
// registered in turn; one request is handled at a time, so a new request is accepted
// only once the last result is in the output register, which waits while output stalls.
// Reset (asynchronous, active low) empties the table and the output register.
// Depends on kct_pkg, kct_cell and keyed_count_table_assert.svh.
`include "keyed_count_table_assert.svh"
module keyed_count_table #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key [31:0], amount [63:32]
  input  logic [1:0]  s_axis_tuser,   // kind [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // count [31:0]
  output logic [1:0]  m_axis_tuser    // status [1:0]
);
  import kct_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_ACT    = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  used_q;
  kind_e            kind_q;
  logic [DataW-1:0] key_q;
  logic [DataW-1:0] amount_q;
  logic             start_q;
  logic             hit_q;
  logic [DataW-1:0] hit_cnt_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [DataW-1:0] out_count_q;

  tok_t             tok [TABLE_DEPTH+1];
  wr_t              wr;
  logic             in_fire;
  logic             act_fire;
  logic [DataW:0]   sum;
  logic [DataW-1:0] sat;
  status_e          status;
  logic [DataW-1:0] count;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign act_fire      = (state_q == S_ACT) && (!out_valid_q || m_axis_tready);

  // Token enters the first cell in the cycle after the request is captured.
  assign tok[0].valid = start_q;
  assign tok[0].hit   = 1'b0;
  assign tok[0].count = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    kct_cell #(
      .CNT_W (CntW),
      .IDX   (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .used_i (used_q),
      .key_i  (key_q),
      .wr_i   (wr),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  // Saturating add of the change onto the found count.
  assign sum = {hit_cnt_q[DataW-1], hit_cnt_q} + {amount_q[DataW-1], amount_q};
  always_comb begin
    if (sum[DataW] != sum[DataW-1]) begin
      sat = sum[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      sat = sum[DataW-1:0];
    end
  end

  always_comb begin
    status = ST_MISSING;
    count  = '0;
    wr     = '0;
    case (kind_q)
      KIND_INSERT: begin
        if (hit_q) begin
          status = ST_PRESENT;
        end else if (used_q == CntW'(TABLE_DEPTH)) begin
          status = ST_FULL;
        end else begin
          status   = ST_OK;
          count    = amount_q;
          wr.ins   = act_fire;
          wr.count = amount_q;
        end
      end
      KIND_UPDATE: begin
        if (hit_q) begin
          status   = ST_OK;
          count    = sat;
          wr.upd   = act_fire;
          wr.count = sat;
        end
      end
      KIND_LOOKUP: begin
        if (hit_q) begin
          status = ST_OK;
          count  = hit_cnt_q;
        end
      end
      default: begin
        status = ST_MISSING;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_fire) state_d = S_SEARCH;
      S_SEARCH: if (tok[TABLE_DEPTH].valid) state_d = S_ACT;
      S_ACT:    if (act_fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_fire;
      if (wr.ins) begin
        used_q <= used_q + 1'b1;
      end
      if (act_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q   <= kind_e'(s_axis_tuser[1:0]);
      key_q    <= s_axis_tdata[31:0];
      amount_q <= s_axis_tdata[63:32];
    end
    if (state_q == S_SEARCH && tok[TABLE_DEPTH].valid) begin
      hit_q     <= tok[TABLE_DEPTH].hit;
      hit_cnt_q <= tok[TABLE_DEPTH].count;
    end
    if (act_fire) begin
      out_status_q <= status;
      out_count_q  <= count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_count_q;
  assign m_axis_tuser  = out_status_q;

  `KCT_ASSERT_ALWAYS(a_used_bound, clk_i, !rst_ni || used_q <= CntW'(TABLE_DEPTH),
                     "fill count past table depth")
  `KCT_ASSERT(a_tail_in_search, clk_i, rst_ni,
              tok[TABLE_DEPTH].valid |-> state_q == S_SEARCH,
              "search token arrived outside search")
  `KCT_ASSERT(a_act_gives_result, clk_i, rst_ni, act_fire |=> m_axis_tvalid,
              "finished request left no result")
  `KCT_ASSERT(a_count_zero_on_fail, clk_i, rst_ni,
              (m_axis_tvalid && m_axis_tuser != ST_OK) |-> m_axis_tdata == '0,
              "nonzero count with failing status")

endmodule
